[src/bsim_pkg.sv]
// Shared types, constants and command codes of the bank switch mapper.
package bsim_pkg;

   localparam int DATA_W    = 8;
   localparam int ADDR_W    = 16;
   localparam int OP_W      = 2;
   localparam int CHR_SLOTS = 8;
   localparam int SLOT_W    = 3;
   localparam int PRG_W     = 9;
   localparam int DIV_W     = 11;
   localparam int STEP_W    = 3;
   localparam int CNT_W     = 16;
   localparam int KIND_W    = 4;
   localparam int CSR_IDX_W = 1;

   localparam logic [STEP_W-1:0] STEP_LAST       = STEP_W'(DATA_W - 1);
   localparam logic [CNT_W-1:0]  CYCLES_PER_LINE = 16'd113;
   localparam logic [CNT_W-1:0]  COUNT_IDLE      = 16'hffff;

   // Queue between front and back, and result queue
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = 1;
   localparam int Q_CNT_W = 2;
   localparam logic [Q_CNT_W-1:0] Q_FULL = Q_CNT_W'(Q_DEPTH);

   localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
   localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
   localparam logic [OP_W-1:0] OP_INIT  = 2'd2;

   localparam logic [ADDR_W-1:0] ADDR_PRG0      = 16'h8000;
   localparam logic [ADDR_W-1:0] ADDR_PRG1      = 16'ha000;
   localparam logic [ADDR_W-1:0] ADDR_PRG2      = 16'hc000;
   localparam logic [ADDR_W-1:0] ADDR_MIRROR    = 16'h9000;
   localparam logic [ADDR_W-1:0] ADDR_ARM       = 16'h9003;
   localparam logic [ADDR_W-1:0] ADDR_COPY      = 16'h9004;
   localparam logic [ADDR_W-1:0] ADDR_RELOAD_HI = 16'h9005;
   localparam logic [ADDR_W-1:0] ADDR_RELOAD_LO = 16'h9006;
   localparam logic [ADDR_W-1:0] ADDR_CHR       = 16'hb000;

   localparam logic [KIND_W-1:0] CMD_NOP       = 4'd0;
   localparam logic [KIND_W-1:0] CMD_PRG0      = 4'd1;
   localparam logic [KIND_W-1:0] CMD_PRG1      = 4'd2;
   localparam logic [KIND_W-1:0] CMD_PRG2      = 4'd3;
   localparam logic [KIND_W-1:0] CMD_MIRROR    = 4'd4;
   localparam logic [KIND_W-1:0] CMD_ARM       = 4'd5;
   localparam logic [KIND_W-1:0] CMD_COPY      = 4'd6;
   localparam logic [KIND_W-1:0] CMD_RELOAD_HI = 4'd7;
   localparam logic [KIND_W-1:0] CMD_RELOAD_LO = 4'd8;
   localparam logic [KIND_W-1:0] CMD_CHR       = 4'd9;
   localparam logic [KIND_W-1:0] CMD_TICK      = 4'd10;
   localparam logic [KIND_W-1:0] CMD_INIT      = 4'd11;

   localparam logic [CSR_IDX_W-1:0] CSR_PRG_UNITS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHR_UNITS = 1'd1;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [SLOT_W-1:0] slot;
      logic [DATA_W-1:0] data;
   } cmd_type;

   typedef struct packed {
      logic [DATA_W-1:0] prg_units;
      logic [DATA_W-1:0] chr_units;
   } cfg_type;

   typedef struct packed {
      logic              start;
      logic [DATA_W-1:0] dividend;
      logic [DIV_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] remainder;
   } div_rsp_type;

   typedef struct packed {
      logic                          irq_request;
      logic                          mirroring_select;
      logic [DATA_W-1:0]             prg_bank_8000;
      logic [DATA_W-1:0]             prg_bank_a000;
      logic [PRG_W-1:0]              prg_bank_c000;
      logic [PRG_W-1:0]              prg_bank_e000;
      logic [CHR_SLOTS*DATA_W-1:0]   chr_banks_packed;
   } rsp_type;

endpackage

[src/bsim_front.sv]
// Front end: accepts items, decodes them into commands and queues them.
module bsim_front
   import bsim_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic [OP_W-1:0]   req_operation,
   input  logic [ADDR_W-1:0] req_address,
   input  logic [DATA_W-1:0] req_data,
   output logic              cmd_valid,
   output cmd_type           cmd,
   input  logic              cmd_pop
);

   cmd_type              q_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [Q_CNT_W-1:0]   cnt_ff, cnt_in;
   cmd_type              decoded;
   logic                 push_ok;
   logic                 pop_ok;

   always_comb begin
      decoded.slot = req_address[SLOT_W-1:0];
      decoded.data = req_data;
      unique case (req_operation)
         OP_WRITE: begin
            priority if (req_address == ADDR_PRG0)      decoded.kind = CMD_PRG0;
            else if (req_address == ADDR_PRG1)      decoded.kind = CMD_PRG1;
            else if (req_address == ADDR_PRG2)      decoded.kind = CMD_PRG2;
            else if (req_address == ADDR_MIRROR)    decoded.kind = CMD_MIRROR;
            else if (req_address == ADDR_ARM)       decoded.kind = CMD_ARM;
            else if (req_address == ADDR_COPY)      decoded.kind = CMD_COPY;
            else if (req_address == ADDR_RELOAD_HI) decoded.kind = CMD_RELOAD_HI;
            else if (req_address == ADDR_RELOAD_LO) decoded.kind = CMD_RELOAD_LO;
            else if (req_address[ADDR_W-1:SLOT_W] == ADDR_CHR[ADDR_W-1:SLOT_W])
               decoded.kind = CMD_CHR;
            else                                    decoded.kind = CMD_NOP;
         end
         OP_TICK: decoded.kind = CMD_TICK;
         OP_INIT: decoded.kind = CMD_INIT;
         default: decoded.kind = CMD_NOP;
      endcase
   end

   assign req_full  = (cnt_ff == Q_FULL);
   assign cmd_valid = (cnt_ff != '0);
   assign cmd       = q_ff[rd_ff];
   assign push_ok   = req_push && !req_full;
   assign pop_ok    = cmd_pop && cmd_valid;

   always_comb begin
      wr_in  = wr_ff + Q_PTR_W'(push_ok);
      rd_in  = rd_ff + Q_PTR_W'(pop_ok);
      cnt_in = cnt_ff + Q_CNT_W'(push_ok) - Q_CNT_W'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[wr_ff] <= decoded;
      end
   end

endmodule

[src/bsim_mod.sv]
// Bit-serial remainder unit: one dividend bit per cycle.
module bsim_mod
   import bsim_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [DIV_W-1:0]   rem_ff, rem_in;
   logic [DATA_W-1:0]  num_ff, num_in;
   logic [DIV_W-1:0]   den_ff, den_in;
   logic [DIV_W:0]     trial;
   logic [DIV_W:0]     diff;

   assign trial = {rem_ff, num_ff[DATA_W-1]};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         num_in  = div_req.dividend;
         den_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in  = (trial >= {1'b0, den_ff}) ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
         num_in  = {num_ff[DATA_W-2:0], 1'b0};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.remainder = rem_ff[DATA_W-1:0];

endmodule

[src/bsim_back.sv]
// Back end: mapper state, command execution and result queue.
module bsim_back
   import bsim_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        cmd_valid,
   input  cmd_type     cmd,
   output logic        cmd_pop,
   output div_req_type div_req,
   input  div_rsp_type div_rsp,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output rsp_type     rsp
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]          state_ff, state_in;
   cmd_type             cur_ff, cur_in;
   logic                irq_ff, irq_in;
   logic [DATA_W-1:0]   prg0_ff, prg0_in;
   logic [DATA_W-1:0]   prg1_ff, prg1_in;
   logic [PRG_W-1:0]    prg2_ff, prg2_in;
   logic [DATA_W-1:0]   chr_ff [CHR_SLOTS];
   logic [DATA_W-1:0]   chr_in [CHR_SLOTS];
   logic                mirror_ff, mirror_in;
   logic                armed_ff, armed_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    reload_ff, reload_in;

   rsp_type             res_q_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]  res_wr_ff, res_wr_in, res_rd_ff, res_rd_in;
   logic [Q_CNT_W-1:0]  res_cnt_ff, res_cnt_in;
   logic                res_push;
   logic                res_pop;
   rsp_type             snapshot;

   logic [PRG_W-1:0]    prg_div;
   logic [DIV_W-1:0]    chr_div;
   logic [DIV_W-1:0]    divisor;
   logic                page_we;
   logic [DATA_W-1:0]   page_val;
   logic [KIND_W-1:0]   page_kind;
   logic [SLOT_W-1:0]   page_slot;

   assign prg_div = {1'b0, cfg.prg_units} << 1;
   assign chr_div = {3'b000, cfg.chr_units} << 3;
   assign divisor = (cmd.kind == CMD_CHR) ? chr_div : {2'b00, prg_div};

   always_comb begin
      state_in    = state_ff;
      cur_in      = cur_ff;
      irq_in      = irq_ff;
      prg0_in     = prg0_ff;
      prg1_in     = prg1_ff;
      prg2_in     = prg2_ff;
      chr_in      = chr_ff;
      mirror_in   = mirror_ff;
      armed_in    = armed_ff;
      count_in    = count_ff;
      reload_in   = reload_ff;
      cmd_pop     = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = cmd.data;
      div_req.divisor  = divisor;
      res_push    = 1'b0;
      page_we     = 1'b0;
      page_val    = cmd.data;
      page_kind   = cmd.kind;
      page_slot   = cmd.slot;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && res_cnt_ff != Q_FULL) begin
               cmd_pop  = 1'b1;
               cur_in   = cmd;
               irq_in   = 1'b0;
               state_in = ST_EMIT;
               unique case (cmd.kind)
                  CMD_PRG0, CMD_PRG1, CMD_PRG2, CMD_CHR: begin
                     if (divisor != '0) begin
                        if ({3'b000, cmd.data} < divisor) begin
                           page_we = 1'b1;
                        end else begin
                           div_req.start = 1'b1;
                           state_in      = ST_DIV;
                        end
                     end
                  end
                  CMD_MIRROR:    mirror_in = cmd.data[6];
                  CMD_ARM:       armed_in  = cmd.data[7];
                  CMD_COPY:      count_in  = reload_ff;
                  CMD_RELOAD_HI: reload_in = {cmd.data, reload_ff[DATA_W-1:0]};
                  CMD_RELOAD_LO: reload_in = {reload_ff[CNT_W-1:DATA_W], cmd.data};
                  CMD_TICK: begin
                     if (armed_ff) begin
                        if (count_ff <= CYCLES_PER_LINE) begin
                           irq_in   = 1'b1;
                           armed_in = 1'b0;
                           count_in = COUNT_IDLE;
                        end else begin
                           count_in = count_ff - CYCLES_PER_LINE;
                        end
                     end
                  end
                  CMD_INIT: begin
                     prg0_in = '0;
                     prg1_in = DATA_W'(1);
                     prg2_in = (cfg.prg_units == '0) ? '0 : prg_div - PRG_W'(2);
                     if (cfg.chr_units != '0) begin
                        for (int i = 0; i < CHR_SLOTS; i++) begin
                           chr_in[i] = DATA_W'(i);
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               page_we   = 1'b1;
               page_val  = div_rsp.remainder;
               page_kind = cur_ff.kind;
               page_slot = cur_ff.slot;
               state_in  = ST_EMIT;
            end
         end
         ST_EMIT: begin
            res_push = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      if (page_we) begin
         unique case (page_kind)
            CMD_PRG0: prg0_in = page_val;
            CMD_PRG1: prg1_in = page_val;
            CMD_PRG2: prg2_in = {1'b0, page_val};
            CMD_CHR:  chr_in[page_slot] = page_val;
            default: ;
         endcase
      end
   end

   always_comb begin
      snapshot.irq_request      = irq_ff;
      snapshot.mirroring_select = mirror_ff;
      snapshot.prg_bank_8000    = prg0_ff;
      snapshot.prg_bank_a000    = prg1_ff;
      snapshot.prg_bank_c000    = prg2_ff;
      snapshot.prg_bank_e000    = (cfg.prg_units == '0) ? '0 : prg_div - PRG_W'(1);
      for (int i = 0; i < CHR_SLOTS; i++) begin
         snapshot.chr_banks_packed[i*DATA_W +: DATA_W] = chr_ff[i];
      end
   end

   assign rsp_empty = (res_cnt_ff == '0);
   assign res_pop   = rsp_pop && !rsp_empty;
   assign rsp       = res_q_ff[res_rd_ff];

   always_comb begin
      res_wr_in  = res_wr_ff + Q_PTR_W'(res_push);
      res_rd_in  = res_rd_ff + Q_PTR_W'(res_pop);
      res_cnt_in = res_cnt_ff + Q_CNT_W'(res_push) - Q_CNT_W'(res_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         irq_ff     <= 1'b0;
         prg0_ff    <= '0;
         prg1_ff    <= '0;
         prg2_ff    <= '0;
         for (int i = 0; i < CHR_SLOTS; i++) begin
            chr_ff[i] <= '0;
         end
         mirror_ff  <= 1'b0;
         armed_ff   <= 1'b0;
         count_ff   <= '0;
         reload_ff  <= '0;
         res_wr_ff  <= '0;
         res_rd_ff  <= '0;
         res_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         irq_ff     <= irq_in;
         prg0_ff    <= prg0_in;
         prg1_ff    <= prg1_in;
         prg2_ff    <= prg2_in;
         chr_ff     <= chr_in;
         mirror_ff  <= mirror_in;
         armed_ff   <= armed_in;
         count_ff   <= count_in;
         reload_ff  <= reload_in;
         res_wr_ff  <= res_wr_in;
         res_rd_ff  <= res_rd_in;
         res_cnt_ff <= res_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (res_push) begin
         res_q_ff[res_wr_ff] <= snapshot;
      end
   end

endmodule

[src/bank_switch_scanline_irq_mapper.sv]
// Top level of the bank switch mapper with scanline interrupt counter.
// Items enter on the req_ queue port: push with operation, address and data while
// full is low. Every item gives exactly one result on the rsp_ queue port: while
// empty is low the oldest result stands on the rsp_ ports, pop takes it.
// csr_ writes set the program and character ROM sizes; write them only while idle.
// A two-entry command queue sits between the decoder and the execution unit, and a
// two-entry result queue sits behind the execution unit, so input keeps flowing
// while the receiver stalls until both queues are full.
// An item is decoded into the command queue, taken by the execution unit, and its
// result written into the result queue. A page write whose data is not below the
// page count goes first through the bit-serial remainder unit, one step for each
// of the 8 data bits. The execution unit handles one item at a time and takes no
// new item before the result of the last one is queued.
// Reset clears all bank, mirroring and counter state and both queues, and sets the
// ROM sizes to two program units and no character ROM.
module bank_switch_scanline_irq_mapper
   import bsim_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   output logic                        req_full,
   input  logic [OP_W-1:0]             req_operation,
   input  logic [ADDR_W-1:0]           req_address,
   input  logic [DATA_W-1:0]           req_data,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output logic                        rsp_irq_request,
   output logic                        rsp_mirroring_select,
   output logic [DATA_W-1:0]           rsp_prg_bank_8000,
   output logic [DATA_W-1:0]           rsp_prg_bank_a000,
   output logic [PRG_W-1:0]            rsp_prg_bank_c000,
   output logic [PRG_W-1:0]            rsp_prg_bank_e000,
   output logic [CHR_SLOTS*DATA_W-1:0] rsp_chr_banks_packed,
   input  logic                        csr_write_enable,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [DATA_W-1:0]           csr_write_data
);

   cfg_type     cfg_ff, cfg_in;
   logic        cmd_valid;
   cmd_type     cmd;
   logic        cmd_pop;
   div_req_type div_req;
   div_rsp_type div_rsp;
   rsp_type     rsp;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_PRG_UNITS: cfg_in.prg_units = csr_write_data;
            CSR_CHR_UNITS: cfg_in.chr_units = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prg_units <= DATA_W'(2);
         cfg_ff.chr_units <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bsim_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_operation (req_operation),
      .req_address   (req_address),
      .req_data      (req_data),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .cmd_pop       (cmd_pop)
   );

   bsim_mod u_mod (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   bsim_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .div_req   (div_req),
      .div_rsp   (div_rsp),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp       (rsp)
   );

   assign rsp_irq_request      = rsp.irq_request;
   assign rsp_mirroring_select = rsp.mirroring_select;
   assign rsp_prg_bank_8000    = rsp.prg_bank_8000;
   assign rsp_prg_bank_a000    = rsp.prg_bank_a000;
   assign rsp_prg_bank_c000    = rsp.prg_bank_c000;
   assign rsp_prg_bank_e000    = rsp.prg_bank_e000;
   assign rsp_chr_banks_packed = rsp.chr_banks_packed;

endmodule

[src/bsim_checker.sv]
// Port-level checks of the mapper, bound to the top level.
module bsim_checker
   import bsim_pkg::*;
(
   input logic                        clock,
   input logic                        reset,
   input logic                        req_full,
   input logic                        rsp_empty,
   input logic                        rsp_pop,
   input logic                        rsp_irq_request,
   input logic [DATA_W-1:0]           rsp_prg_bank_8000,
   input logic [PRG_W-1:0]            rsp_prg_bank_c000,
   input logic [CHR_SLOTS*DATA_W-1:0] rsp_chr_banks_packed
);

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   a_reset_room: assert property (@(posedge clock) reset |=> !req_full)
      else $error("input queue full after reset");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty)
      else $error("waiting item withdrawn");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> $stable(rsp_irq_request) && $stable(rsp_prg_bank_8000)
         && $stable(rsp_prg_bank_c000) && $stable(rsp_chr_banks_packed))
      else $error("waiting item changed");

endmodule

bind bank_switch_scanline_irq_mapper bsim_checker u_checker (
   .clock                (clock),
   .reset                (reset),
   .req_full             (req_full),
   .rsp_empty            (rsp_empty),
   .rsp_pop              (rsp_pop),
   .rsp_irq_request      (rsp_irq_request),
   .rsp_prg_bank_8000    (rsp_prg_bank_8000),
   .rsp_prg_bank_c000    (rsp_prg_bank_c000),
   .rsp_chr_banks_packed (rsp_chr_banks_packed)
);
